// ===== design/mws_pkg.sv =====
// Shared types and constants for the MOSFET wave scattering pipeline.
// No dependencies; every other design file but mws_checker imports this package.
`default_nettype none
package mws_pkg;

    localparam int WAVE_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int X_W     = 50;
    localparam int DISC_W  = 36;
    localparam int ROOT_W  = 18;
    localparam int REM_W   = 22;
    localparam int C1_W    = 22;
    localparam int SQ_STEPS = 6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_GAMMA = 2'd1;
    localparam logic [1:0] CFG_PORTS = 2'd2;

    typedef enum logic [1:0] {
        REG_OFF,
        REG_SAT,
        REG_TRI,
        REG_REV
    } region_t;

    // Values that ride along with an item to the output stage.
    typedef struct packed {
        logic                     valid;
        logic signed [WAVE_W-1:0] a1;
        logic signed [WAVE_W-1:0] a2;
        logic                     two;
    } side_t;

    // Item state between region choice and current scaling.
    typedef struct packed {
        side_t                    side;
        region_t                  region;
        logic signed [X_W-1:0]    y_rev;
        logic signed [C1_W-1:0]   c1;
        logic [DISC_W-1:0]        disc;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
    } mid_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_acc_t;

    // One digit of a restoring square root.
    function automatic sq_acc_t sqrt_step(input sq_acc_t acc, input logic [1:0] bits);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        sq_acc_t          res;
        rem_sh = {acc.rem[REM_W-3:0], bits};
        trial  = {2'b00, acc.root, 2'b01};
        if (rem_sh >= trial) begin
            res.rem  = rem_sh - trial;
            res.root = {acc.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_sh;
            res.root = {acc.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/mws_front.sv =====
// Front of the pipeline: input register, wave-to-voltage product, region choice.
// Depends on mws_pkg.
`default_nettype none
module mws_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          ce,
    input  wire logic                          in_valid,
    input  wire logic signed [31:0]            in_a1,
    input  wire logic signed [31:0]            in_a2,
    input  wire logic                          in_gate,
    input  wire logic [31:0]                   alpha_gain,
    input  wire logic                          two_ports,
    output mws_pkg::mid_t                      mid_out
);
    import mws_pkg::*;

    side_t                    s1_reg, s2_reg;
    logic                     g1_reg, g2_reg;
    logic signed [WAVE_W:0]   a_reg;
    logic signed [2*WAVE_W+1:0] prod_reg;
    mid_t                     mid_reg;
    logic signed [WAVE_W:0]   a_next;
    mid_t                     mid_next;
    logic signed [X_W-1:0]    x;
    logic signed [X_W-1:0]    x_lim;
    logic [18:0]              x_lo;
    logic [DISC_W-1:0]        pos;
    logic [DISC_W-1:0]        negp;

    // Port difference, or the first wave alone with one port.
    always_comb begin
        if (two_ports) begin
            a_next = {in_a1[WAVE_W-1], in_a1} - {in_a2[WAVE_W-1], in_a2};
        end else begin
            a_next = {in_a1[WAVE_W-1], in_a1};
        end
    end

    // Input and product stages; valid bits clear on reset, everything shifts on ce.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
        end else if (ce) begin
            s1_reg.valid <= in_valid;
            s2_reg.valid <= s1_reg.valid;
            s1_reg.a1    <= in_a1;
            s1_reg.a2    <= in_a2;
            s1_reg.two   <= two_ports;
            g1_reg       <= in_gate;
            a_reg        <= a_next;
            s2_reg.a1    <= s1_reg.a1;
            s2_reg.a2    <= s1_reg.a2;
            s2_reg.two   <= s1_reg.two;
            g2_reg       <= g1_reg;
            prod_reg     <= a_reg * $signed({1'b0, alpha_gain});
        end
    end

    // Region choice, discriminant and linear coefficient of the triode root.
    always_comb begin
        x     = prod_reg[FRAC_W +: X_W];
        x_lo  = x[18:0];
        x_lim = s2_reg.two ? X_W'(3 * 65536) : X_W'(2 * 65536);
        if (s2_reg.two) begin
            pos  = DISC_W'(36'h2_4000_0000) + DISC_W'(36'h4_0000_0000);
            negp = {16'd0, x_lo, 1'b0} << FRAC_W;
        end else begin
            pos  = DISC_W'(36'h1_4000_0000) + DISC_W'(36'h1_0000_0000);
            negp = {17'd0, x_lo} << FRAC_W;
        end
        mid_next.side = s2_reg;
        if (g2_reg && x >= x_lim) begin
            mid_next.region = REG_SAT;
        end else if (g2_reg && !x[X_W-1]) begin
            mid_next.region = REG_TRI;
        end else if (x[X_W-1]) begin
            mid_next.region = REG_REV;
        end else begin
            mid_next.region = REG_OFF;
        end
        mid_next.y_rev = s2_reg.two ? (x >>> 1) : x;
        if (s2_reg.two) begin
            mid_next.c1 = C1_W'(32768) + ((C1_W'(65536) - {3'd0, x_lo}) <<< 1);
        end else begin
            mid_next.c1 = C1_W'(32768) + (C1_W'(65536) - {3'd0, x_lo});
        end
        mid_next.disc = pos - negp;
        mid_next.rem  = '0;
        mid_next.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg.side.valid <= 1'b0;
        end else if (ce) begin
            mid_reg.side.valid <= mid_next.side.valid;
            mid_reg.side.a1    <= mid_next.side.a1;
            mid_reg.side.a2    <= mid_next.side.a2;
            mid_reg.side.two   <= mid_next.side.two;
            mid_reg.region     <= mid_next.region;
            mid_reg.y_rev      <= mid_next.y_rev;
            mid_reg.c1         <= mid_next.c1;
            mid_reg.disc       <= mid_next.disc;
            mid_reg.rem        <= mid_next.rem;
            mid_reg.root       <= mid_next.root;
        end
    end

    assign mid_out = mid_reg;

endmodule
`default_nettype wire

// ===== design/mws_sqrt_stage.sv =====
// One stage of the pipelined triode square root, six result bits per stage.
// Depends on mws_pkg.
`default_nettype none
module mws_sqrt_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          ce,
    input  wire mws_pkg::mid_t mid_in,
    output mws_pkg::mid_t      mid_out
);
    import mws_pkg::*;

    mid_t    mid_reg;
    mid_t    mid_next;
    sq_acc_t acc;

    // Consume two discriminant bits per digit, most significant first.
    always_comb begin
        mid_next  = mid_in;
        acc.rem   = mid_in.rem;
        acc.root  = mid_in.root;
        for (int i = 0; i < SQ_STEPS; i++) begin
            acc = sqrt_step(acc, mid_next.disc[DISC_W-1 -: 2]);
            mid_next.disc = {mid_next.disc[DISC_W-3:0], 2'b00};
        end
        mid_next.rem  = acc.rem;
        mid_next.root = acc.root;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg.side.valid <= 1'b0;
        end else if (ce) begin
            mid_reg.side.valid <= mid_next.side.valid;
            mid_reg.side.a1    <= mid_next.side.a1;
            mid_reg.side.a2    <= mid_next.side.a2;
            mid_reg.side.two   <= mid_next.side.two;
            mid_reg.region     <= mid_next.region;
            mid_reg.y_rev      <= mid_next.y_rev;
            mid_reg.c1         <= mid_next.c1;
            mid_reg.disc       <= mid_next.disc;
            mid_reg.rem        <= mid_next.rem;
            mid_reg.root       <= mid_next.root;
        end
    end

    assign mid_out = mid_reg;

endmodule
`default_nettype wire

// ===== design/mws_back.sv =====
// Back of the pipeline: normalized current, current scaling and reflected waves.
// Depends on mws_pkg.
`default_nettype none
module mws_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                ce,
    input  wire mws_pkg::mid_t       mid_in,
    input  wire logic [31:0]         gamma_gain,
    output logic                     out_valid,
    output logic signed [31:0]       out_b1,
    output logic signed [31:0]       out_b2,
    output logic signed [31:0]       out_cur
);
    import mws_pkg::*;

    side_t                    s7_reg, s8_reg, s9_reg;
    logic signed [X_W-1:0]    y_reg;
    logic [56:0]              pp_lo_reg;
    logic signed [57:0]       pp_hi_reg;
    logic signed [WAVE_W-1:0] cur_reg;
    logic                     out_valid_reg;
    logic signed [WAVE_W-1:0] b1_reg, b2_reg, cur_out_reg;
    logic signed [X_W-1:0]    y_next;
    logic signed [23:0]       num;
    logic signed [23:0]       num_d;
    logic signed [82:0]       full;
    logic signed [66:0]       scaled;
    logic signed [WAVE_W-1:0] cur_next;
    logic signed [WAVE_W:0]   d1, d2;
    logic signed [WAVE_W-1:0] b1_next, b2_next;

    // Normalized current for each region; triode root is clamped to [0, 1].
    always_comb begin
        num   = $signed({6'd0, mid_in.root}) - 24'(mid_in.c1);
        num_d = mid_in.side.two ? (num >>> 2) : num;
        case (mid_in.region)
            REG_SAT: y_next = X_W'(65536);
            REG_REV: y_next = mid_in.y_rev;
            REG_TRI: begin
                if (num[23]) begin
                    y_next = '0;
                end else if (num_d > 24'sd65536) begin
                    y_next = X_W'(65536);
                end else begin
                    y_next = X_W'(num_d);
                end
            end
            default: y_next = '0;
        endcase
    end

    // Wide product split into two partial products, joined in the next stage.
    always_comb begin
        full   = $signed({pp_hi_reg, 25'd0}) + $signed({26'd0, pp_lo_reg});
        scaled = full[82:16];
        if (scaled[66:31] != {36{scaled[66]}}) begin
            cur_next = scaled[66] ? {1'b1, {(WAVE_W-1){1'b0}}} : {1'b0, {(WAVE_W-1){1'b1}}};
        end else begin
            cur_next = scaled[WAVE_W-1:0];
        end
    end

    // Reflected waves, saturated to the wave range; the second is zero with one port.
    always_comb begin
        d1 = {s9_reg.a1[WAVE_W-1], s9_reg.a1} - {cur_reg[WAVE_W-1], cur_reg};
        d2 = {s9_reg.a2[WAVE_W-1], s9_reg.a2} + {cur_reg[WAVE_W-1], cur_reg};
        if (d1[WAVE_W] != d1[WAVE_W-1]) begin
            b1_next = d1[WAVE_W] ? {1'b1, {(WAVE_W-1){1'b0}}} : {1'b0, {(WAVE_W-1){1'b1}}};
        end else begin
            b1_next = d1[WAVE_W-1:0];
        end
        if (!s9_reg.two) begin
            b2_next = '0;
        end else if (d2[WAVE_W] != d2[WAVE_W-1]) begin
            b2_next = d2[WAVE_W] ? {1'b1, {(WAVE_W-1){1'b0}}} : {1'b0, {(WAVE_W-1){1'b1}}};
        end else begin
            b2_next = d2[WAVE_W-1:0];
        end
    end

    // Back stages; valid bits clear on reset, everything shifts on ce.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_reg.valid  <= 1'b0;
            s8_reg.valid  <= 1'b0;
            s9_reg.valid  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            s7_reg.valid  <= mid_in.side.valid;
            s8_reg.valid  <= s7_reg.valid;
            s9_reg.valid  <= s8_reg.valid;
            out_valid_reg <= s9_reg.valid;
            s7_reg.a1     <= mid_in.side.a1;
            s7_reg.a2     <= mid_in.side.a2;
            s7_reg.two    <= mid_in.side.two;
            y_reg         <= y_next;
            s8_reg.a1     <= s7_reg.a1;
            s8_reg.a2     <= s7_reg.a2;
            s8_reg.two    <= s7_reg.two;
            pp_lo_reg     <= {32'd0, y_reg[24:0]} * {25'd0, gamma_gain};
            pp_hi_reg     <= $signed(y_reg[X_W-1:25]) * $signed({1'b0, gamma_gain});
            s9_reg.a1     <= s8_reg.a1;
            s9_reg.a2     <= s8_reg.a2;
            s9_reg.two    <= s8_reg.two;
            cur_reg       <= cur_next;
            b1_reg        <= b1_next;
            b2_reg        <= b2_next;
            cur_out_reg   <= cur_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_b1    = b1_reg;
    assign out_b2    = b2_reg;
    assign out_cur   = cur_out_reg;

endmodule
`default_nettype wire

// ===== design/mosfet_wave_scattering.sv =====
// Top level of the wave-digital MOSFET switch: config registers and pipeline.
// Depends on mws_pkg, mws_front, mws_sqrt_stage and mws_back.
//
//  Channel  Ports          Payload (low bit up)
//  input    s_tdata[71:0]  incident_wave_1, incident_wave_2, gate_on, zero pad
//  result   m_tdata[95:0]  reflected_wave_1, reflected_wave_2, drain_current
//  config   cfg_*          index 0 alpha_gain, 1 gamma_gain, 2 port_count
//
// One item per cycle enters while the output is not stalled.
// Its result passes the three square-root stages and the split current product.
// The whole pipeline advances together; a stall on m_tready freezes every stage
// and s_tready follows it, so nothing is lost or repeated.
// Reset is synchronous and active low; it clears valid bits and restores gains and port count.
`default_nettype none
module mosfet_wave_scattering (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // [31:0] a1, [63:32] a2, [64] gate_on
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [31:0] b1, [63:32] b2, [95:64] current
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import mws_pkg::*;

    logic [31:0]       alpha_reg, gamma_reg;
    logic [1:0]        ports_reg;
    logic              ce;
    mid_t              mid3, mid4, mid5, mid6;
    logic signed [31:0] b1, b2, cur;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= 32'h0001_0000;
            gamma_reg <= 32'h0001_0000;
            ports_reg <= 2'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALPHA: alpha_reg <= cfg_data;
                CFG_GAMMA: gamma_reg <= cfg_data;
                CFG_PORTS: ports_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances unless the output holds an item that is not taken.
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    mws_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (s_tvalid),
        .in_a1      (s_tdata[31:0]),
        .in_a2      (s_tdata[63:32]),
        .in_gate    (s_tdata[64]),
        .alpha_gain (alpha_reg),
        .two_ports  (ports_reg == 2'd2),
        .mid_out    (mid3)
    );

    mws_sqrt_stage u_sq0 (.aclk(aclk), .aresetn(aresetn), .ce(ce), .mid_in(mid3), .mid_out(mid4));
    mws_sqrt_stage u_sq1 (.aclk(aclk), .aresetn(aresetn), .ce(ce), .mid_in(mid4), .mid_out(mid5));
    mws_sqrt_stage u_sq2 (.aclk(aclk), .aresetn(aresetn), .ce(ce), .mid_in(mid5), .mid_out(mid6));

    mws_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .mid_in     (mid6),
        .gamma_gain (gamma_reg),
        .out_valid  (m_tvalid),
        .out_b1     (b1),
        .out_b2     (b2),
        .out_cur    (cur)
    );

    assign m_tdata = {cur, b2, b1};

endmodule
`default_nettype wire

// ===== design/mws_checker.sv =====
// Port-level checks for mosfet_wave_scattering, attached by bind.
// Depends only on the top level's ports.
`default_nettype none
module mws_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // With the output empty the block always takes a new item.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A stalled output holds off the input side.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind mosfet_wave_scattering mws_checker u_mws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
